// ===== hw/rtl/irc_pkg.sv =====
package irc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned CreditW  = 7;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ARCADE_MODE     = 3'd0,
        CFG_FREE_PLAY       = 3'd1,
        CFG_INITIAL_DELAY   = 3'd2,
        CFG_REPEAT_INTERVAL = 3'd3,
        CFG_CREDIT_LIMIT    = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        REQ_FRAME       = 1'b0,
        REQ_CREDIT_DOWN = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        START_NONE = 2'd0,
        START_P1   = 2'd1,
        START_P2   = 2'd2
    } t_start;

    localparam logic               RstArcadeMode     = 1'b1;
    localparam logic               RstFreePlay       = 1'b0;
    localparam logic [7:0]         RstInitialDelay   = 8'd20;
    localparam logic [7:0]         RstRepeatInterval = 8'd4;
    localparam logic [CreditW-1:0] RstCreditLimit    = 7'd99;

    // remapped system bit positions
    localparam int unsigned SysStart1 = 0;
    localparam int unsigned SysStart2 = 2;
    localparam int unsigned SysCoin1  = 4;
    localparam int unsigned SysCoin2  = 5;

    typedef struct packed {
        logic               arcade_mode;
        logic               free_play;
        logic [7:0]         initial_delay;
        logic [7:0]         repeat_interval;
        logic [CreditW-1:0] credit_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] held;
        logic [7:0] pressed;
        logic [7:0] rpt;
    } t_player_res;

    typedef struct packed {
        logic       req_type;
        logic [7:0] p1_raw;
        logic [7:0] p2_raw;
        logic [7:0] status_a_raw;
        logic [7:0] status_b_raw;
        logic       attract_mode;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         p1_held;
        logic [7:0]         p1_pressed;
        logic [7:0]         p1_repeat;
        logic [7:0]         p2_held;
        logic [7:0]         p2_pressed;
        logic [7:0]         p2_repeat;
        logic [7:0]         sys_held;
        logic [7:0]         sys_pressed;
        logic [CreditW-1:0] p1_credit_count;
        logic [CreditW-1:0] p2_credit_count;
        logic [CreditW-1:0] credit_available;
        logic [1:0]         start_request;
    } t_out_word;

endpackage

// ===== hw/rtl/irc_in_if.sv =====
interface irc_in_if;
    logic              valid;
    logic              ready;
    irc_pkg::t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/irc_out_if.sv =====
interface irc_out_if;
    logic               valid;
    logic               ready;
    irc_pkg::t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/irc_player.sv =====
module irc_player (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_frame,
    input  logic                 i_update,
    input  logic [7:0]           i_raw,
    input  irc_pkg::t_cfg        i_cfg,
    output irc_pkg::t_player_res o_res
);

    logic [7:0] r_last;
    logic [7:0] r_countdown;
    logic [7:0] n_countdown;
    logic [7:0] w_held;
    logic [7:0] w_pressed;
    logic [7:0] w_rpt;

    always_comb begin
        w_held      = ~i_raw;
        w_pressed   = w_held & ~r_last;
        w_rpt       = '0;
        n_countdown = r_countdown;
        if (w_held == '0) begin
            n_countdown = '0;
        end else if (w_pressed != '0) begin
            n_countdown = i_cfg.initial_delay;
            w_rpt       = w_pressed;
        end else if (r_countdown != '0) begin
            n_countdown = r_countdown - 8'd1;
        end else begin
            n_countdown = i_cfg.repeat_interval;
            w_rpt       = w_held;
        end
    end

    always_comb begin
        if (i_frame) begin
            o_res.held    = w_held;
            o_res.pressed = w_pressed;
            o_res.rpt     = w_rpt;
        end else begin
            o_res.held    = r_last;
            o_res.pressed = '0;
            o_res.rpt     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_countdown <= '0;
        end else if (i_update && i_frame) begin
            r_last      <= w_held;
            r_countdown <= n_countdown;
        end
    end

endmodule

// ===== hw/rtl/input_repeat_and_coin_credit.sv =====
// path: an accepted word is held in the input register, then its result in the result register
// throughput: one word per cycle, input register and result register both
//   advance whenever the result register is empty or being taken
// reset: synchronous active low, clears edge, timer and credit state, restores
//   config defaults, and empties both stages
module input_repeat_and_coin_credit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    irc_in_if.sink                          i_in,
    irc_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [irc_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [irc_pkg::CfgDataW-1:0]    i_cfg_data
);

    irc_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    irc_pkg::t_in_word  r_in;
    logic               r_out_valid;
    irc_pkg::t_out_word r_out;
    irc_pkg::t_out_word n_out;

    logic [7:0]                  r_sys_last;
    logic [irc_pkg::CreditW-1:0] r_p1_credits;
    logic [irc_pkg::CreditW-1:0] r_p2_credits;
    logic [irc_pkg::CreditW-1:0] n_p1_credits;
    logic [irc_pkg::CreditW-1:0] n_p2_credits;

    logic                 w_move;
    logic                 w_frame;
    logic                 w_bypass;
    logic [7:0]           w_a;
    logic [7:0]           w_b;
    logic [7:0]           w_sys_held;
    logic [7:0]           w_sys_pressed;
    logic                 w_can1;
    logic                 w_can2;
    irc_pkg::t_start      w_start;
    irc_pkg::t_player_res w_p1;
    irc_pkg::t_player_res w_p2;

    assign w_move     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_move;
    assign w_frame    = (r_in.req_type == irc_pkg::REQ_FRAME);
    assign w_bypass   = !r_cfg.arcade_mode || r_cfg.free_play;

    irc_player u_p1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (w_frame),
        .i_update (w_move),
        .i_raw    (r_in.p1_raw),
        .i_cfg    (r_cfg),
        .o_res    (w_p1)
    );

    irc_player u_p2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (w_frame),
        .i_update (w_move),
        .i_raw    (r_in.p2_raw),
        .i_cfg    (r_cfg),
        .o_res    (w_p2)
    );

    always_comb begin
        w_a           = ~r_in.status_a_raw;
        w_b           = ~r_in.status_b_raw;
        w_sys_held    = r_sys_last;
        w_sys_pressed = '0;
        n_p1_credits  = r_p1_credits;
        n_p2_credits  = r_p2_credits;
        w_start       = irc_pkg::START_NONE;
        w_can1        = 1'b0;
        w_can2        = 1'b0;
        if (!w_frame) begin
            if (!w_bypass && r_p1_credits != '0) begin
                n_p1_credits = r_p1_credits - 7'd1;
            end
        end else begin
            w_sys_held    = {w_a[7], w_a[2:0], w_b[3:0]};
            w_sys_pressed = w_sys_held & ~r_sys_last;
            if (r_cfg.arcade_mode) begin
                if (w_sys_pressed[irc_pkg::SysCoin1] && r_p1_credits < r_cfg.credit_limit) begin
                    n_p1_credits = r_p1_credits + 7'd1;
                end
                if (w_sys_pressed[irc_pkg::SysCoin2] && r_p2_credits < r_cfg.credit_limit) begin
                    n_p2_credits = r_p2_credits + 7'd1;
                end
            end
            if (r_in.attract_mode) begin
                w_can1 = w_bypass || n_p1_credits != '0;
                w_can2 = w_bypass || n_p2_credits != '0;
                if (w_can1 && w_sys_pressed[irc_pkg::SysStart1]) begin
                    w_start = irc_pkg::START_P1;
                end else if (w_can2 && w_sys_pressed[irc_pkg::SysStart2]) begin
                    w_start = irc_pkg::START_P2;
                end
            end
        end

        n_out.p1_held          = w_p1.held;
        n_out.p1_pressed       = w_p1.pressed;
        n_out.p1_repeat        = w_p1.rpt;
        n_out.p2_held          = w_p2.held;
        n_out.p2_pressed       = w_p2.pressed;
        n_out.p2_repeat        = w_p2.rpt;
        n_out.sys_held         = w_sys_held;
        n_out.sys_pressed      = w_sys_pressed;
        n_out.p1_credit_count  = n_p1_credits;
        n_out.p2_credit_count  = n_p2_credits;
        n_out.credit_available = w_bypass ? r_cfg.credit_limit : n_p1_credits;
        n_out.start_request    = w_start;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arcade_mode     <= irc_pkg::RstArcadeMode;
            r_cfg.free_play       <= irc_pkg::RstFreePlay;
            r_cfg.initial_delay   <= irc_pkg::RstInitialDelay;
            r_cfg.repeat_interval <= irc_pkg::RstRepeatInterval;
            r_cfg.credit_limit    <= irc_pkg::RstCreditLimit;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                irc_pkg::CFG_ARCADE_MODE:     r_cfg.arcade_mode     <= i_cfg_data[0];
                irc_pkg::CFG_FREE_PLAY:       r_cfg.free_play       <= i_cfg_data[0];
                irc_pkg::CFG_INITIAL_DELAY:   r_cfg.initial_delay   <= i_cfg_data;
                irc_pkg::CFG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_data;
                irc_pkg::CFG_CREDIT_LIMIT: begin
                    r_cfg.credit_limit <= i_cfg_data[irc_pkg::CreditW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sys_last   <= '0;
            r_p1_credits <= '0;
            r_p2_credits <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid  <= 1'b1;
                r_sys_last   <= w_sys_held;
                r_p1_credits <= n_p1_credits;
                r_p2_credits <= n_p2_credits;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ===== hw/rtl/irc_checker.sv =====
module irc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input irc_pkg::t_out_word i_out_payload
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled result changed");

    a_edges_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_payload.p1_pressed & ~i_out_payload.p1_held) == 8'd0
            && (i_out_payload.p2_pressed & ~i_out_payload.p2_held) == 8'd0
            && (i_out_payload.sys_pressed & ~i_out_payload.sys_held) == 8'd0)
        else $error("pressed bit not held");

    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_payload.p1_repeat & ~i_out_payload.p1_held) == 8'd0
            && (i_out_payload.p2_repeat & ~i_out_payload.p2_held) == 8'd0)
        else $error("repeat bit not held");

    a_start_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.start_request != irc_pkg::START_NONE
            |-> i_out_payload.sys_pressed[irc_pkg::SysStart1]
            || i_out_payload.sys_pressed[irc_pkg::SysStart2])
        else $error("start request without start edge");

endmodule

bind input_repeat_and_coin_credit irc_checker u_irc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

// ===== tb/sv/input_repeat_and_coin_credit_tb.sv =====
`timescale 1ns / 100ps

module input_repeat_and_coin_credit_tb;

    localparam int unsigned CycleLimit = 150000;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [irc_pkg::CfgIdxW-1:0]  cfg_idx;
    logic [irc_pkg::CfgDataW-1:0] cfg_data;

    irc_in_if  in_ch ();
    irc_out_if out_ch ();

    input_repeat_and_coin_credit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    irc_pkg::t_cfg               model_cfg;
    logic [7:0]                  last_held [2];
    logic [7:0]                  countdown [2];
    logic [7:0]                  last_sys;
    logic [irc_pkg::CreditW-1:0] credits [2];

    irc_pkg::t_out_word expected_results [$];
    int unsigned        error_count;
    int unsigned        cycle_count;
    logic               no_idle;

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void model_reset();
        model_cfg.arcade_mode     = irc_pkg::RstArcadeMode;
        model_cfg.free_play       = irc_pkg::RstFreePlay;
        model_cfg.initial_delay   = irc_pkg::RstInitialDelay;
        model_cfg.repeat_interval = irc_pkg::RstRepeatInterval;
        model_cfg.credit_limit    = irc_pkg::RstCreditLimit;
        for (int p = 0; p < 2; p++) begin
            last_held[p[0]] = '0;
            countdown[p[0]] = '0;
            credits[p[0]]   = '0;
        end
        last_sys = '0;
    endfunction

    function automatic logic credits_bypassed();
        return !model_cfg.arcade_mode || model_cfg.free_play;
    endfunction

    function automatic irc_pkg::t_player_res player_step(input logic p,
                                                         input logic [7:0] held);
        irc_pkg::t_player_res r;
        r.held    = held;
        r.pressed = held & ~last_held[p];
        if (held == 8'h00) begin
            countdown[p] = 8'h00;
            r.rpt = 8'h00;
        end else if (r.pressed != 8'h00) begin
            countdown[p] = model_cfg.initial_delay;
            r.rpt = r.pressed;
        end else if (countdown[p] != 8'h00) begin
            countdown[p] = countdown[p] - 8'h01;
            r.rpt = 8'h00;
        end else begin
            countdown[p] = model_cfg.repeat_interval;
            r.rpt = held;
        end
        last_held[p] = held;
        return r;
    endfunction

    function automatic irc_pkg::t_out_word predict_word(input irc_pkg::t_in_word w);
        irc_pkg::t_out_word   r;
        irc_pkg::t_player_res pa;
        irc_pkg::t_player_res pb;
        logic [7:0]           sa;
        logic [7:0]           sb;
        logic [7:0]           sh;
        logic [7:0]           sp;
        logic                 can1;
        logic                 can2;
        irc_pkg::t_start      start;

        r = '0;
        start = irc_pkg::START_NONE;
        r.p1_held  = last_held[0];
        r.p2_held  = last_held[1];
        r.sys_held = last_sys;
        if (w.req_type == irc_pkg::REQ_CREDIT_DOWN) begin
            if (!credits_bypassed() && credits[0] != '0) begin
                credits[0] = credits[0] - 7'd1;
            end
        end else begin
            pa = player_step(1'b0, ~w.p1_raw);
            pb = player_step(1'b1, ~w.p2_raw);
            r.p1_held    = pa.held;
            r.p1_pressed = pa.pressed;
            r.p1_repeat  = pa.rpt;
            r.p2_held    = pb.held;
            r.p2_pressed = pb.pressed;
            r.p2_repeat  = pb.rpt;

            sa = ~w.status_a_raw;
            sb = ~w.status_b_raw;
            sh = {sa[7], sa[2:0], sb[3:0]};
            sp = sh & ~last_sys;
            last_sys = sh;
            r.sys_held    = sh;
            r.sys_pressed = sp;

            if (model_cfg.arcade_mode) begin
                if (sp[irc_pkg::SysCoin1] && credits[0] < model_cfg.credit_limit) begin
                    credits[0] = credits[0] + 7'd1;
                end
                if (sp[irc_pkg::SysCoin2] && credits[1] < model_cfg.credit_limit) begin
                    credits[1] = credits[1] + 7'd1;
                end
            end

            if (w.attract_mode) begin
                can1 = credits_bypassed() || credits[0] != '0;
                can2 = credits_bypassed() || credits[1] != '0;
                if (can1 && sp[irc_pkg::SysStart1]) begin
                    start = irc_pkg::START_P1;
                end else if (can2 && sp[irc_pkg::SysStart2]) begin
                    start = irc_pkg::START_P2;
                end
            end
        end
        r.p1_credit_count  = credits[0];
        r.p2_credit_count  = credits[1];
        r.credit_available = credits_bypassed() ? model_cfg.credit_limit : credits[0];
        r.start_request    = start;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        irc_pkg::t_out_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no word pending");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("p1_held", 32'(want.p1_held), 32'(out_ch.payload.p1_held));
                check_field("p1_pressed", 32'(want.p1_pressed),
                            32'(out_ch.payload.p1_pressed));
                check_field("p1_repeat", 32'(want.p1_repeat),
                            32'(out_ch.payload.p1_repeat));
                check_field("p2_held", 32'(want.p2_held), 32'(out_ch.payload.p2_held));
                check_field("p2_pressed", 32'(want.p2_pressed),
                            32'(out_ch.payload.p2_pressed));
                check_field("p2_repeat", 32'(want.p2_repeat),
                            32'(out_ch.payload.p2_repeat));
                check_field("sys_held", 32'(want.sys_held), 32'(out_ch.payload.sys_held));
                check_field("sys_pressed", 32'(want.sys_pressed),
                            32'(out_ch.payload.sys_pressed));
                check_field("p1_credit_count", 32'(want.p1_credit_count),
                            32'(out_ch.payload.p1_credit_count));
                check_field("p2_credit_count", 32'(want.p2_credit_count),
                            32'(out_ch.payload.p2_credit_count));
                check_field("credit_available", 32'(want.credit_available),
                            32'(out_ch.payload.credit_available));
                check_field("start_request", 32'(want.start_request),
                            32'(out_ch.payload.start_request));
            end
        end
    end

    // result side back-pressure
    initial begin : result_sink
        int unsigned gap;
        out_ch.ready = 1'b0;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready && rst_n));
        end
    end

    task automatic send_word(input irc_pkg::t_req req, input logic [7:0] p1,
                             input logic [7:0] p2, input logic [7:0] sa,
                             input logic [7:0] sb, input logic att);
        irc_pkg::t_in_word w;
        int unsigned       gap;
        w.req_type     = req;
        w.p1_raw       = p1;
        w.p2_raw       = p2;
        w.status_a_raw = sa;
        w.status_b_raw = sb;
        w.attract_mode = att;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        expected_results.push_back(predict_word(w));
    endtask

    task automatic send_credit_down();
        send_word(irc_pkg::REQ_CREDIT_DOWN, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input irc_pkg::t_cfg_idx idx,
                             input logic [irc_pkg::CfgDataW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic arcade, input logic free,
                                input logic [7:0] delay, input logic [7:0] interval,
                                input logic [irc_pkg::CreditW-1:0] limit);
        drain();
        cfg_write(irc_pkg::CFG_ARCADE_MODE, irc_pkg::CfgDataW'(arcade));
        cfg_write(irc_pkg::CFG_FREE_PLAY, irc_pkg::CfgDataW'(free));
        cfg_write(irc_pkg::CFG_INITIAL_DELAY, delay);
        cfg_write(irc_pkg::CFG_REPEAT_INTERVAL, interval);
        cfg_write(irc_pkg::CFG_CREDIT_LIMIT, irc_pkg::CfgDataW'(limit));
        cfg_we <= 1'b0;
        model_cfg.arcade_mode     = arcade;
        model_cfg.free_play       = free;
        model_cfg.initial_delay   = delay;
        model_cfg.repeat_interval = interval;
        model_cfg.credit_limit    = limit;
    endtask

    task automatic test_repeat_timer();
        apply_config(1'b1, 1'b0, 8'd2, 8'd1, 7'd99);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
        repeat (4) send_word(irc_pkg::REQ_FRAME, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'hF0, 8'h0F, 8'hFF, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    endtask

    task automatic test_coin_credits();
        apply_config(1'b1, 1'b0, 8'd20, 8'd4, 7'd2);
        // start refused without credit, then floor at zero
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b1);
        send_credit_down();
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'h7B, 8'hF5, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // coin1 saturates, coin2 adds
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFC, 8'hFF, 1'b0);
        // both starts at once, player one wins
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFA, 1'b1);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 1'b1);
        repeat (3) send_credit_down();
    endtask

    task automatic test_lowered_limit();
        apply_config(1'b1, 1'b0, 8'd0, 8'd0, 7'd0);
        send_word(irc_pkg::REQ_FRAME, 8'h00, 8'hFF, 8'hFD, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'h00, 8'hFF, 8'hFF, 8'hFB, 1'b1);
    endtask

    task automatic test_console_and_free_play();
        apply_config(1'b0, 1'b0, 8'd255, 8'd255, 7'd127);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 1'b1);
        send_credit_down();
        apply_config(1'b1, 1'b1, 8'd255, 8'd255, 7'd127);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(irc_pkg::REQ_FRAME, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 1'b1);
        send_credit_down();
    endtask

    task automatic test_random_traffic();
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [7:0]  sa;
        logic [7:0]  sb;
        int unsigned roll;
        int unsigned k;
        p1 = 8'hFF;
        p2 = 8'hFF;
        sa = 8'hFF;
        sb = 8'hFF;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_config(1'b1, 1'b0, 8'd0, 8'd0, 7'd0);
                1: apply_config(1'b1, 1'b0, 8'd255, 8'd255, 7'd127);
                default: apply_config($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                                      8'($urandom_range(0, 8)), 8'($urandom_range(0, 4)),
                                      ($urandom_range(0, 3) == 0) ? 7'd127
                                                                  : 7'($urandom_range(0, 6)));
            endcase
            no_idle = (phase == 2);
            for (int i = 0; i < 185; i++) begin
                if (phase == 3 && i == 90) begin
                    drain();
                end
                roll = $urandom_range(0, 15);
                if (roll == 0) begin
                    send_credit_down();
                end else if (roll == 1) begin
                    send_word(irc_pkg::REQ_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom));
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        p1 = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                                         : p1 ^ (8'h01 << $urandom_range(0, 7));
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        p2 = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                                         : p2 ^ (8'h01 << $urandom_range(0, 7));
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        k = $urandom_range(0, 3);
                        sa = sa ^ (8'h01 << ((k == 3) ? 7 : k));
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        sb = sb ^ (8'h01 << $urandom_range(0, 3));
                    end
                    if ($urandom_range(0, 15) == 0) begin
                        sa = 8'($urandom);
                        sb = 8'($urandom);
                    end
                    send_word(irc_pkg::REQ_FRAME, p1, p2, sa, sb, $urandom_range(0, 3) != 0);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        model_reset();
        error_count   = 0;
        cycle_count   = 0;
        no_idle       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_repeat_timer();
        test_coin_credits();
        test_lowered_limit();
        test_console_and_free_play();
        test_random_traffic();

        drain();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
